[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the region nesting op checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RNOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define RNOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/rnoc_pkg.sv]
// Shared constants and types of the region nesting op checker.
// No dependencies; imported by rnoc_ctrl, rnoc_dp and the top level.
`default_nettype none

package rnoc_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef logic [1:0] marker_t;
  localparam marker_t MK_IF    = 2'd0;
  localparam marker_t MK_FOR   = 2'd1;
  localparam marker_t MK_WHILE = 2'd2;
  localparam marker_t MK_DEF   = 2'd3;

  typedef logic [3:0] mode_t;
  localparam mode_t MODE_IF        = 4'd0;
  localparam mode_t MODE_END_IF    = 4'd1;
  localparam mode_t MODE_FOR       = 4'd2;
  localparam mode_t MODE_END_FOR   = 4'd3;
  localparam mode_t MODE_WHILE     = 4'd4;
  localparam mode_t MODE_END_WHILE = 4'd5;
  localparam mode_t MODE_DEF       = 4'd6;
  localparam mode_t MODE_END_DEF   = 4'd7;
  localparam mode_t MODE_RETURN    = 4'd8;
  localparam mode_t MODE_CONST     = 4'd9;
  localparam mode_t MODE_BINOP     = 4'd10;
  localparam mode_t MODE_CMP       = 4'd11;
  localparam mode_t MODE_CALL      = 4'd12;
  localparam mode_t MODE_QUANTUM   = 4'd13;
  localparam mode_t MODE_OTHER     = 4'd14;
  localparam mode_t MODE_FINISH    = 4'd15;

  typedef logic [3:0] type_code_t;
  localparam type_code_t TY_INT   = 4'd0;
  localparam type_code_t TY_ANGLE = 4'd1;
  localparam type_code_t TY_BIT   = 4'd2;

  typedef logic [4:0] status_t;
  localparam status_t ST_OK           = 5'd0;
  localparam status_t ST_NO_TARGET    = 5'd1;
  localparam status_t ST_IF_COUNT     = 5'd2;
  localparam status_t ST_IF_TYPE      = 5'd3;
  localparam status_t ST_END_IF       = 5'd4;
  localparam status_t ST_FOR_COUNT    = 5'd5;
  localparam status_t ST_FOR_TYPE     = 5'd6;
  localparam status_t ST_END_FOR      = 5'd7;
  localparam status_t ST_END_WHILE    = 5'd8;
  localparam status_t ST_NESTED_DEF   = 5'd9;
  localparam status_t ST_END_DEF      = 5'd10;
  localparam status_t ST_RETURN       = 5'd11;
  localparam status_t ST_CONST        = 5'd12;
  localparam status_t ST_BINOP_COUNT  = 5'd13;
  localparam status_t ST_BINOP_TYPE   = 5'd14;
  localparam status_t ST_CMP_COUNT    = 5'd15;
  localparam status_t ST_CMP_TYPE     = 5'd16;
  localparam status_t ST_ARITY        = 5'd17;
  localparam status_t ST_UNPAIRED     = 5'd18;
  localparam status_t ST_OVERFLOW     = 5'd19;
  localparam status_t ST_DONE         = 5'd20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the accepted item
    logic exec;      // evaluate an ordinary item and emit its status
    logic fin_tgt;   // finish: target check, start the stack walk
    logic fin_walk;  // finish: emit one unpaired marker
    logic fin_done;  // finish: emit done, clear state
    logic walk_sel;  // memory read address follows the walk index
  } rnoc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_finish;   // item on the input is a finish item
    logic out_free;    // output register can take a result this cycle
    logic level_zero;  // no open markers
    logic walk_last;   // current walk entry is the top of the stack
  } rnoc_stat_t;

endpackage

`default_nettype wire

[hw/rtl/region_nesting_op_checker_core.sv]
// Region nesting op checker: checks a stream of summarized IR ops for
// well-formed region nesting and per-op rules, one result per ordinary op.
//
// Channels: s_axis takes one op per item (tuser = op kind, tdata = counts,
// type codes and expected arity). m_axis returns status items; tlast marks
// the final result of an input item. cfg_* writes the target-present flag;
// write it only while the block is idle (cfg_ready_o is always high).
// Sequencing: the accept edge latches an ordinary op and reads the top of
// the marker stack memory; once the output register is free, the op is
// evaluated and loads it. A finish item walks the stack one entry per cycle
// through the memory read port while the output register is free; its
// steps are accept, target check, one per open marker, then done. The
// output register lets the next item be accepted while a result still waits.
// Stall: when m_axis_tready is low the pending result holds and evaluation
// waits for the output register to free up; nothing is lost.
// Reset: rst_ni (async, active low) empties the stack, clears the function
// flag, op counter and target flag, and drops any pending result.
`default_nettype none

module region_nesting_op_checker_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: operand_count[3:0], result_count[7:4], first_operand_type[11:8],
  //        second_operand_type[15:12], first_result_type[19:16],
  //        expected_arity[24:20] (signed), zero pad [31:25]
  input  logic [rnoc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: mode[3:0]
  input  logic [rnoc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: status_code[4:0], unpaired_marker[7:5], op_number[23:8]
  output logic [rnoc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i
);
  import rnoc_pkg::*;

  rnoc_cmd_t  cmd;
  rnoc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rnoc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rnoc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

[hw/rtl/rnoc_ctrl.sv]
// Controller state machine of the region nesting op checker.
// Depends on rnoc_pkg; drives rnoc_dp through rnoc_cmd_t.
`default_nettype none

module rnoc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  rnoc_pkg::rnoc_stat_t stat_i,
  output rnoc_pkg::rnoc_cmd_t  cmd_o
);
  import rnoc_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_FIN_TGT  = 3'd2;
  localparam logic [2:0] S_FIN_WALK = 3'd3;
  localparam logic [2:0] S_FIN_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.in_finish ? S_FIN_TGT : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FIN_TGT: begin
        cmd_o.walk_sel = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.fin_tgt = 1'b1;
          state_d       = stat_i.level_zero ? S_FIN_DONE : S_FIN_WALK;
        end
      end
      S_FIN_WALK: begin
        cmd_o.walk_sel = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.fin_walk = 1'b1;
          if (stat_i.walk_last) begin
            state_d = S_FIN_DONE;
          end
        end
      end
      S_FIN_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.fin_done = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rnoc_dp.sv]
// Datapath of the region nesting op checker: marker stack memory, level,
// function flag, op counter, rule checks and the output register.
// Depends on rnoc_pkg and assert_macros.svh; commanded by rnoc_ctrl.
`default_nettype none
`include "assert_macros.svh"

module rnoc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rnoc_pkg::rnoc_cmd_t                 cmd_i,
  output rnoc_pkg::rnoc_stat_t                stat_o,
  input  logic [rnoc_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic [rnoc_pkg::IN_TUSER_W-1:0]     s_tuser_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_data_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [rnoc_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic                                m_tlast_o
);
  import rnoc_pkg::*;

  // Latched item
  mode_t      mode_q;
  logic [3:0] nops_q, nres_q;
  type_code_t t0_q, t1_q, tr_q;
  logic [4:0] arity_q;

  logic target_q;

  // Stack and state
  marker_t          stack_mem [STACK_DEPTH];
  marker_t          rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic [LVL_W-1:0] level_q, level_d;
  logic [LVL_W-1:0] walk_q, walk_d;
  logic             in_fn_q, in_fn_d;
  logic [15:0]      op_cnt_q, op_cnt_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  status_t     out_code_q, out_code_d;
  logic [2:0]  out_mk_q, out_mk_d;
  logic [15:0] out_num_q, out_num_d;
  logic        out_last_q, out_last_d;

  // Evaluation results
  status_t code;
  logic    do_push, do_pop, set_fn, clr_fn;
  marker_t push_mk;
  logic    full, top_if, top_for, top_while, top_def, has_top;
  logic    emit, out_free;

  assign full      = (level_q == LVL_W'(STACK_DEPTH));
  assign has_top   = (level_q != '0);
  assign top_if    = has_top && (rd_q == MK_IF);
  assign top_for   = has_top && (rd_q == MK_FOR);
  assign top_while = has_top && (rd_q == MK_WHILE);
  assign top_def   = has_top && (rd_q == MK_DEF);

  always_comb begin
    code    = ST_OK;
    do_push = 1'b0;
    do_pop  = 1'b0;
    set_fn  = 1'b0;
    clr_fn  = 1'b0;
    push_mk = MK_IF;
    unique case (mode_q)
      MODE_IF: begin
        push_mk = MK_IF;
        if (nops_q != 4'd1) begin
          code = ST_IF_COUNT;
        end else begin
          if (t0_q != TY_BIT && t0_q != TY_INT) code = ST_IF_TYPE;
          if (full) begin
            if (code == ST_OK) code = ST_OVERFLOW;
          end else begin
            do_push = 1'b1;
          end
        end
      end
      MODE_END_IF: begin
        if (top_if) do_pop = 1'b1;
        else        code   = ST_END_IF;
      end
      MODE_FOR: begin
        push_mk = MK_FOR;
        if (nops_q != 4'd2) begin
          code = ST_FOR_COUNT;
        end else begin
          if (t0_q != TY_INT || t1_q != TY_INT) code = ST_FOR_TYPE;
          if (full) begin
            if (code == ST_OK) code = ST_OVERFLOW;
          end else begin
            do_push = 1'b1;
          end
        end
      end
      MODE_END_FOR: begin
        if (top_for) do_pop = 1'b1;
        else         code   = ST_END_FOR;
      end
      MODE_WHILE: begin
        push_mk = MK_WHILE;
        if (full) code    = ST_OVERFLOW;
        else      do_push = 1'b1;
      end
      MODE_END_WHILE: begin
        if (top_while) do_pop = 1'b1;
        else           code   = ST_END_WHILE;
      end
      MODE_DEF: begin
        push_mk = MK_DEF;
        if (in_fn_q) code = ST_NESTED_DEF;
        if (!full) begin
          do_push = 1'b1;
          set_fn  = 1'b1;
        end else if (code == ST_OK) begin
          code = ST_OVERFLOW;
        end
      end
      MODE_END_DEF: begin
        if (top_def) begin
          do_pop = 1'b1;
          clr_fn = 1'b1;
        end else begin
          code = ST_END_DEF;
        end
      end
      MODE_RETURN: begin
        if (!in_fn_q) code = ST_RETURN;
      end
      MODE_CONST: begin
        if (nops_q != 4'd0 || nres_q != 4'd1) code = ST_CONST;
      end
      MODE_BINOP: begin
        if (nops_q != 4'd2 || nres_q != 4'd1) begin
          code = ST_BINOP_COUNT;
        end else if (t0_q != t1_q || (t0_q != TY_INT && t0_q != TY_ANGLE)) begin
          code = ST_BINOP_TYPE;
        end
      end
      MODE_CMP: begin
        if (nops_q != 4'd2 || nres_q != 4'd1) code = ST_CMP_COUNT;
        else if (tr_q != TY_BIT)               code = ST_CMP_TYPE;
      end
      MODE_QUANTUM: begin
        // negative arity means unchecked
        if (!arity_q[4] && nops_q != arity_q[3:0]) code = ST_ARITY;
      end
      default: begin
        code = ST_OK;
      end
    endcase
  end

  // Walk index and memory read address
  always_comb begin
    walk_d = walk_q;
    if (cmd_i.fin_tgt)       walk_d = '0;
    else if (cmd_i.fin_walk) walk_d = walk_q + LVL_W'(1);
  end

  assign rd_addr = cmd_i.walk_sel ? walk_d[IDX_W-1:0]
                                  : IDX_W'(level_q - LVL_W'(1));

  // State updates
  always_comb begin
    level_d  = level_q;
    in_fn_d  = in_fn_q;
    op_cnt_d = op_cnt_q;
    if (cmd_i.exec) begin
      if (do_push)     level_d = level_q + LVL_W'(1);
      else if (do_pop) level_d = level_q - LVL_W'(1);
      if (set_fn)      in_fn_d = 1'b1;
      else if (clr_fn) in_fn_d = 1'b0;
      op_cnt_d = op_cnt_q + 16'd1;
    end else if (cmd_i.fin_done) begin
      level_d  = '0;
      in_fn_d  = 1'b0;
      op_cnt_d = '0;
    end
  end

  // Output register
  assign out_free = !out_valid_q || m_tready_i;
  assign emit = cmd_i.exec || (cmd_i.fin_tgt && !target_q) || cmd_i.fin_walk ||
                cmd_i.fin_done;

  always_comb begin
    out_code_d = out_code_q;
    out_mk_d   = out_mk_q;
    out_num_d  = out_num_q;
    out_last_d = out_last_q;
    if (cmd_i.exec) begin
      out_code_d = code;
      out_mk_d   = '0;
      out_last_d = 1'b1;
    end else if (cmd_i.fin_tgt) begin
      out_code_d = ST_NO_TARGET;
      out_mk_d   = '0;
      out_last_d = 1'b0;
    end else if (cmd_i.fin_walk) begin
      out_code_d = ST_UNPAIRED;
      out_mk_d   = {1'b0, rd_q} + 3'd1;
      out_last_d = 1'b0;
    end else if (cmd_i.fin_done) begin
      out_code_d = ST_DONE;
      out_mk_d   = '0;
      out_last_d = 1'b1;
    end
    if (emit) out_num_d = op_cnt_q;
    if (emit)            out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
    else                 out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      in_fn_q     <= 1'b0;
      op_cnt_q    <= '0;
      target_q    <= 1'b0;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
    end else begin
      level_q     <= level_d;
      in_fn_q     <= in_fn_d;
      op_cnt_q    <= op_cnt_d;
      out_valid_q <= out_valid_d;
      walk_q      <= walk_d;
      if (cfg_valid_i) target_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= s_tuser_i[3:0];
      nops_q  <= s_tdata_i[3:0];
      nres_q  <= s_tdata_i[7:4];
      t0_q    <= s_tdata_i[11:8];
      t1_q    <= s_tdata_i[15:12];
      tr_q    <= s_tdata_i[19:16];
      arity_q <= s_tdata_i[24:20];
    end
    out_code_q <= out_code_d;
    out_mk_q   <= out_mk_d;
    out_num_q  <= out_num_d;
    out_last_q <= out_last_d;
  end

  // Marker stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_push) begin
      stack_mem[level_q[IDX_W-1:0]] <= push_mk;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign stat_o.in_finish  = (s_tuser_i[3:0] == MODE_FINISH);
  assign stat_o.out_free   = out_free;
  assign stat_o.level_zero = !has_top;
  assign stat_o.walk_last  = ((walk_q + LVL_W'(1)) == level_q);

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_num_q, out_mk_q, out_code_q};
  assign m_tlast_o  = out_last_q;

  `RNOC_ASSERT(a_level_range, (level_q <= LVL_W'(STACK_DEPTH)), "stack level past depth")
  `RNOC_ASSERT(a_emit_slot_free, (emit |-> (!out_valid_q || m_tready_i)), "result overwrites pending result")
  `RNOC_ASSERT(a_fn_has_marker, (in_fn_q |-> (level_q != '0)), "function open with empty stack")

endmodule

`default_nettype wire

[tb/sv/tb_region_nesting_op_checker_core.sv]
`timescale 1ns / 100ps
// Testbench for region_nesting_op_checker_core: sends op items on s_axis, predicts
// each status item in a small scoreboard class and checks m_axis field by field.
// Depends on rnoc_pkg and the core RTL only.

module tb_region_nesting_op_checker_core;
  import rnoc_pkg::*;

  typedef struct {
    mode_t      mode;
    logic [3:0] nops;
    logic [3:0] nres;
    type_code_t t0;
    type_code_t t1;
    type_code_t tr;
    logic [4:0] arity;
  } op_item_t;

  typedef struct {
    status_t     code;
    logic [2:0]  marker;
    logic [15:0] num;
    logic        last;
  } status_item_t;

  // Tracks open regions and queues the status items each accepted op causes.
  class nesting_scoreboard;
    marker_t      regions[STACK_DEPTH];
    int unsigned  depth;
    bit           in_def;
    logic [15:0]  op_idx;
    bit           target_ok;
    status_item_t pending[$];
    int unsigned  errors;

    function new();
      depth = 0;
      in_def = 1'b0;
      op_idx = '0;
      target_ok = 1'b0;
      errors = 0;
    endfunction

    function bit push_region(marker_t mk);
      if (depth >= STACK_DEPTH) return 1'b0;
      regions[depth] = mk;
      depth++;
      return 1'b1;
    endfunction

    function bit pop_region(marker_t mk);
      if (depth == 0 || regions[depth-1] != mk) return 1'b0;
      depth--;
      return 1'b1;
    endfunction

    function void add(status_t code, logic [2:0] marker, logic last);
      status_item_t s;
      s.code = code;
      s.marker = marker;
      s.num = op_idx;
      s.last = last;
      pending.insert(pending.size(), s);
    endfunction

    function void note_op(op_item_t op);
      status_t code;
      code = ST_OK;
      if (op.mode == MODE_FINISH) begin
        if (!target_ok) add(ST_NO_TARGET, 3'd0, 1'b0);
        // unpaired markers come out bottom first
        for (int i = 0; i < depth; i++) add(ST_UNPAIRED, {1'b0, regions[i]} + 3'd1, 1'b0);
        add(ST_DONE, 3'd0, 1'b1);
        depth = 0;
        in_def = 1'b0;
        op_idx = '0;
        return;
      end
      case (op.mode)
        MODE_IF: begin
          if (op.nops != 4'd1) code = ST_IF_COUNT;
          else begin
            if (op.t0 != TY_BIT && op.t0 != TY_INT) code = ST_IF_TYPE;
            if (!push_region(MK_IF) && code == ST_OK) code = ST_OVERFLOW;
          end
        end
        MODE_END_IF: if (!pop_region(MK_IF)) code = ST_END_IF;
        MODE_FOR: begin
          if (op.nops != 4'd2) code = ST_FOR_COUNT;
          else begin
            if (op.t0 != TY_INT || op.t1 != TY_INT) code = ST_FOR_TYPE;
            if (!push_region(MK_FOR) && code == ST_OK) code = ST_OVERFLOW;
          end
        end
        MODE_END_FOR: if (!pop_region(MK_FOR)) code = ST_END_FOR;
        MODE_WHILE: if (!push_region(MK_WHILE)) code = ST_OVERFLOW;
        MODE_END_WHILE: if (!pop_region(MK_WHILE)) code = ST_END_WHILE;
        MODE_DEF: begin
          if (in_def) code = ST_NESTED_DEF;
          if (push_region(MK_DEF)) in_def = 1'b1;
          else if (code == ST_OK) code = ST_OVERFLOW;
        end
        MODE_END_DEF: begin
          // inner end_def clears the flag even with an outer def open
          if (pop_region(MK_DEF)) in_def = 1'b0;
          else code = ST_END_DEF;
        end
        MODE_RETURN: if (!in_def) code = ST_RETURN;
        MODE_CONST: if (op.nops != 4'd0 || op.nres != 4'd1) code = ST_CONST;
        MODE_BINOP: begin
          if (op.nops != 4'd2 || op.nres != 4'd1) code = ST_BINOP_COUNT;
          else if (op.t0 != op.t1 || (op.t0 != TY_INT && op.t0 != TY_ANGLE))
            code = ST_BINOP_TYPE;
        end
        MODE_CMP: begin
          if (op.nops != 4'd2 || op.nres != 4'd1) code = ST_CMP_COUNT;
          else if (op.tr != TY_BIT) code = ST_CMP_TYPE;
        end
        MODE_QUANTUM: if (!op.arity[4] && op.nops != op.arity[3:0]) code = ST_ARITY;
        default: ;
      endcase
      add(code, 3'd0, 1'b1);
      op_idx++;
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_status(logic [OUT_TDATA_W-1:0] data, logic last);
      status_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected status item, expected none actual %h last %b",
                 $time, data, last);
        return;
      end
      want = pending.pop_front();
      compare("status_code", want.code, data[4:0]);
      compare("unpaired_marker", want.marker, data[7:5]);
      compare("op_number", want.num, data[23:8]);
      compare("tlast", want.last, last);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i = 1'b0;

  nesting_scoreboard status_sb;
  bit                calm = 1'b0;
  int unsigned       items_sent = 0;
  int unsigned       stall_left = 0;

  mode_t opener[4] = '{MODE_IF, MODE_FOR, MODE_WHILE, MODE_DEF};
  mode_t closer[4] = '{MODE_END_IF, MODE_END_FOR, MODE_END_WHILE, MODE_END_DEF};
  mode_t plain[7]  = '{MODE_RETURN, MODE_CONST, MODE_BINOP, MODE_CMP, MODE_CALL,
                       MODE_QUANTUM, MODE_OTHER};

  region_nesting_op_checker_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls in bursts that start at random unless calm is set.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      status_sb.check_status(m_axis_tdata, m_axis_tlast);
  end

  function automatic op_item_t mk(mode_t m, int nops = 0, int nres = 0, int t0 = 0,
                                  int t1 = 0, int tr = 0, int ar = -1);
    op_item_t op;
    op.mode = m;
    op.nops = nops[3:0];
    op.nres = nres[3:0];
    op.t0 = t0[3:0];
    op.t1 = t1[3:0];
    op.tr = tr[3:0];
    op.arity = ar[4:0];
    return op;
  endfunction

  // Random fields; when well_formed, patched so the op passes its own rules.
  function automatic op_item_t rand_op(mode_t m, bit well_formed);
    op_item_t op;
    op.mode = m;
    op.nops = 4'($urandom_range(0, 15));
    op.nres = 4'($urandom_range(0, 15));
    op.t0 = 4'($urandom_range(0, 15));
    op.t1 = 4'($urandom_range(0, 15));
    op.tr = 4'($urandom_range(0, 15));
    op.arity = 5'($urandom_range(0, 31));
    if (well_formed) begin
      case (m)
        MODE_IF: begin
          op.nops = 4'd1;
          op.t0 = $urandom_range(0, 1) ? TY_BIT : TY_INT;
        end
        MODE_FOR: begin
          op.nops = 4'd2;
          op.t0 = TY_INT;
          op.t1 = TY_INT;
        end
        MODE_CONST: begin
          op.nops = 4'd0;
          op.nres = 4'd1;
        end
        MODE_BINOP: begin
          op.nops = 4'd2;
          op.nres = 4'd1;
          op.t0 = $urandom_range(0, 1) ? TY_ANGLE : TY_INT;
          op.t1 = op.t0;
        end
        MODE_CMP: begin
          op.nops = 4'd2;
          op.nres = 4'd1;
          op.tr = TY_BIT;
        end
        MODE_QUANTUM: if (!op.arity[4]) op.arity = {1'b0, op.nops};
        default: ;
      endcase
    end
    return op;
  endfunction

  task automatic send_op(input op_item_t op);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op.mode;
    s_axis_tdata <= {7'd0, op.arity, op.tr, op.t1, op.t0, op.nres, op.nops};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    status_sb.note_op(op);
    items_sent++;
  endtask

  // Hold off the sender until every predicted status item has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (status_sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_target(input bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    status_sb.target_ok = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly matched regions with random content, then finish.
  task automatic run_nested();
    int open_kinds[8];
    int n_open;
    int len;
    int kind;
    int r;
    n_open = 0;
    len = $urandom_range(4, 24);
    for (int n = 0; n < len; n++) begin
      r = $urandom_range(0, 9);
      if (r < 3 && n_open < 8) begin
        kind = $urandom_range(0, 3);
        if (kind == 3 && n_open != 0 && $urandom_range(0, 3) != 0) kind = 2;
        send_op(rand_op(opener[kind], $urandom_range(0, 15) != 0));
        open_kinds[n_open] = kind;
        n_open++;
      end else if (r < 6 && n_open != 0) begin
        n_open--;
        kind = open_kinds[n_open];
        if ($urandom_range(0, 15) == 0) kind = $urandom_range(0, 3);
        send_op(rand_op(closer[kind], 1'b1));
      end else begin
        send_op(rand_op(plain[$urandom_range(0, 6)], $urandom_range(0, 7) != 0));
      end
    end
    if ($urandom_range(0, 3) != 0)
      while (n_open != 0) begin
        n_open--;
        send_op(rand_op(closer[open_kinds[n_open]], 1'b1));
      end
    send_op(rand_op(MODE_FINISH, 1'b0));
  endtask

  // Pushes around the stack limit so the finish walks a full or nearly full stack.
  task automatic run_deep();
    int goal;
    goal = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8);
    for (int n = 0; n < goal; n++) begin
      if ($urandom_range(0, 7) == 0)
        send_op(rand_op(plain[$urandom_range(0, 6)], $urandom_range(0, 1) != 0));
      send_op(rand_op(opener[$urandom_range(0, 3)], $urandom_range(0, 3) != 0));
    end
    repeat ($urandom_range(0, 3)) send_op(rand_op(closer[$urandom_range(0, 3)], 1'b1));
    send_op(rand_op(MODE_FINISH, 1'b0));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(3, 16)) send_op(rand_op(mode_t'($urandom_range(0, 15)), 1'b0));
    send_op(rand_op(MODE_FINISH, 1'b0));
  endtask

  initial begin
    int style;
    status_sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_target(1'b0);

    send_op(mk(MODE_IF, 1, 0, TY_BIT));
    send_op(mk(MODE_IF, 1, 0, 15));          // bad predicate type, still opens
    send_op(mk(MODE_IF, 0));                 // count error, nothing opens
    send_op(mk(MODE_END_FOR));
    send_op(mk(MODE_END_IF));
    send_op(mk(MODE_END_IF));
    send_op(mk(MODE_FOR, 2, 0, TY_INT, TY_INT, 0, 15));
    send_op(mk(MODE_FOR, 15, 15, 15, 15, 15, -16));
    send_op(mk(MODE_END_WHILE));
    send_op(mk(MODE_END_FOR));
    send_op(mk(MODE_RETURN));
    send_op(mk(MODE_DEF));
    send_op(mk(MODE_DEF));                   // nested def
    send_op(mk(MODE_END_DEF));
    send_op(mk(MODE_RETURN));                // flag cleared by the inner end_def
    send_op(mk(MODE_END_DEF));
    send_op(mk(MODE_CONST, 15, 15));
    send_op(mk(MODE_BINOP, 2, 1, TY_ANGLE, TY_ANGLE));
    send_op(mk(MODE_BINOP, 2, 1, TY_BIT, TY_BIT));
    send_op(mk(MODE_CMP, 2, 1, 0, 0, TY_INT));
    send_op(mk(MODE_QUANTUM, 15, 0, 3, 3, 0, 15));
    send_op(mk(MODE_QUANTUM, 1, 0, 3, 3, 0, 0));
    send_op(mk(MODE_QUANTUM, 3, 0, 3, 3, 0, -16));
    send_op(mk(MODE_CALL, 15, 15, 15, 15, 15, 15));
    send_op(mk(MODE_WHILE));
    send_op(mk(MODE_FINISH));
    drain();
    write_target(1'b1);

    while (items_sent < 400) begin
      calm = (items_sent >= 340) || ($urandom_range(0, 5) == 0);
      style = $urandom_range(0, 9);
      if (style < 6) run_nested();
      else if (style < 8) run_deep();
      else run_noise();
      if (items_sent < 340 && $urandom_range(0, 4) == 0) begin
        drain();
        write_target($urandom_range(0, 1) != 0);
      end
    end

    drain();
    if (status_sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/rnoc_pkg.sv
hw/rtl/rnoc_ctrl.sv
hw/rtl/rnoc_dp.sv
hw/rtl/region_nesting_op_checker_core.sv
tb/sv/tb_region_nesting_op_checker_core.sv
